// ===== rtl/mi4_pkg.sv =====
// Package with widths, sequencer states and the cofactor term table of the 4x4 inverse.
`timescale 1ns / 1ps
package mi4_pkg;

	localparam int ELEM_W    = 16;
	localparam int FRAC_BITS = 12;
	localparam int COF_W     = 50;
	localparam int ACC_W     = 68;
	localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
	localparam int REM_W     = ACC_W + 1;
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = ELEM_W + 1;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int LO_W      = 26;
	localparam int HI_W      = COF_W - LO_W;
	localparam int BIT_W     = $clog2(NUM_W);
	localparam int LIM_W     = ELEM_W + 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_COF,
		ST_DET,
		ST_DFIN,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic       neg;
	} term_t;

	// One of the six product terms of the signed cofactor used for result k.
	// Result k takes the cofactor of element (row k[1:0], column k[3:2]).
	function automatic term_t term_f(input logic [3:0] k, input logic [2:0] t);
		logic [1:0] sr;
		logic [1:0] sc;
		logic [1:0] r0, r1, r2;
		logic [1:0] p0, p1, p2;
		logic [1:0] c0, c1, c2;
		logic       pneg;
		term_t      res;
		sr = k[1:0];
		sc = k[3:2];
		r0 = (sr == 2'd0) ? 2'd1 : 2'd0;
		r1 = (sr <= 2'd1) ? 2'd2 : 2'd1;
		r2 = (sr <= 2'd2) ? 2'd3 : 2'd2;
		unique case (t)
			3'd0: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; pneg = 1'b0; end
			3'd1: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; pneg = 1'b1; end
			3'd2: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; pneg = 1'b1; end
			3'd3: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; pneg = 1'b0; end
			3'd4: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; pneg = 1'b0; end
			default: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; pneg = 1'b1; end
		endcase
		c0 = (p0 >= sc) ? p0 + 2'd1 : p0;
		c1 = (p1 >= sc) ? p1 + 2'd1 : p1;
		c2 = (p2 >= sc) ? p2 + 2'd1 : p2;
		res.a   = {r0, c0};
		res.b   = {r1, c1};
		res.c   = {r2, c2};
		res.neg = pneg ^ sr[0] ^ sc[0];
		return res;
	endfunction

endpackage

// ===== rtl/mi4_elem_if.sv =====
// Interfaces of the element input channel and the result output channel.
`timescale 1ns / 1ps
interface mi4_elem_if;
	logic                           valid;
	logic                           ready;
	logic signed [mi4_pkg::ELEM_W-1:0] element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface mi4_res_if;
	logic                           valid;
	logic                           ready;
	logic signed [mi4_pkg::ELEM_W-1:0] result_value;
	logic                           singular;
	logic                           saturated;
	logic                           last_element;
	modport source (output valid, output result_value, output singular, output saturated,
		output last_element, input ready);
	modport sink (input valid, input result_value, input singular, input saturated,
		input last_element, output ready);
endinterface

// ===== rtl/matrix_inverse_4x4_core.sv =====
// 4x4 matrix inverse by cofactors and adjugate, with one shared multiplier and divider.
//
//   channel | dir | payload                                               | handshake
//   elem    | in  | element_value (s16, Q4.12, row-major)                 | valid/ready
//   res     | out | result_value (s16), singular, saturated, last_element  | valid/ready
//
// Sixteen items load the matrix at one item per cycle. Each of the 96 cofactor terms,
// a product of three elements, goes twice through the shared 33x17 multiplier; the
// determinant adds four cofactors as low and high halves. Every result takes one
// restoring divider pass. A singular matrix skips the divider and replays its elements.
// The input is ready only while the matrix is loading; results wait in their register
// for as long as the sink stalls. Reset clears the sequencer and counters.
`timescale 1ns / 1ps
module matrix_inverse_4x4_core (
	input  logic          clk,
	input  logic          arst_n,
	mi4_elem_if.sink      elem,
	mi4_res_if.source     res
);

	mi4_pkg::state_t state_q, state_d;

	logic [mi4_pkg::ELEM_W-1:0] store_q [16];
	logic [mi4_pkg::COF_W-1:0]  cof_q [16];

	logic [3:0] load_cnt_q;
	logic [3:0] k_q;
	logic [2:0] t_q;
	logic [1:0] ph_q;
	logic [mi4_pkg::BIT_W-1:0] bit_q;

	logic signed [mi4_pkg::ELEM_W-1:0]   ea_q;
	logic signed [31:0]                  prod_q;
	logic signed [mi4_pkg::ACC_W-1:0]    acc_q;
	logic [mi4_pkg::ACC_W-1:0]           dmag_q;
	logic                                dneg_q;
	logic                                dzero_q;
	logic [mi4_pkg::NUM_W-1:0]           num_q;
	logic [mi4_pkg::NUM_W-1:0]           quo_q;
	logic [mi4_pkg::REM_W-1:0]           rem_q;
	logic                                rneg_q;
	logic [mi4_pkg::ELEM_W-1:0]          res_val_q;
	logic                                res_sing_q;
	logic                                res_sat_q;

	mi4_pkg::term_t term;
	logic [3:0] st_addr;
	logic [3:0] cof_addr;
	logic signed [mi4_pkg::ELEM_W-1:0]  st_rd;
	logic signed [mi4_pkg::COF_W-1:0]   cof_rd;
	logic signed [mi4_pkg::MUL_A_W-1:0] mul_a;
	logic signed [mi4_pkg::MUL_B_W-1:0] mul_b;
	logic signed [mi4_pkg::MUL_P_W-1:0] mul_p;
	logic signed [mi4_pkg::ACC_W-1:0]   addend;
	logic signed [mi4_pkg::ACC_W-1:0]   acc_sum;
	logic [mi4_pkg::REM_W-1:0]          rem_sh;
	logic                               rem_ge;
	logic [mi4_pkg::COF_W-1:0]          cof_mag;
	logic [mi4_pkg::LIM_W-1:0]          lim;
	logic                               sat;
	logic [mi4_pkg::LIM_W-1:0]          mag;
	logic                               in_acc;
	logic                               out_acc;

	assign in_acc  = elem.valid && elem.ready;
	assign out_acc = res.valid && res.ready;

	assign term = mi4_pkg::term_f(k_q, t_q);

	// Store read address follows the step of the sequencer.
	always_comb begin
		st_addr  = k_q;
		cof_addr = k_q;
		if (state_q == mi4_pkg::ST_COF) begin
			unique case (ph_q)
				2'd0:    st_addr = term.a;
				2'd1:    st_addr = term.b;
				default: st_addr = term.c;
			endcase
		end else if (state_q == mi4_pkg::ST_DET) begin
			st_addr  = {2'b00, k_q[1:0]};
			cof_addr = {k_q[1:0], 2'b00};
		end
	end

	assign st_rd  = store_q[st_addr];
	assign cof_rd = cof_q[cof_addr];

	// Shared multiplier. In the determinant pass each cofactor goes in as a low and a
	// high half so that one narrow multiplier covers the wide operand.
	always_comb begin
		mul_a = mi4_pkg::MUL_A_W'(ea_q);
		if (state_q == mi4_pkg::ST_COF && ph_q == 2'd2) begin
			mul_a = mi4_pkg::MUL_A_W'(prod_q);
		end else if (state_q == mi4_pkg::ST_DET) begin
			if (ph_q == 2'd0) begin
				mul_a = mi4_pkg::MUL_A_W'({1'b0, cof_rd[mi4_pkg::LO_W-1:0]});
			end else begin
				mul_a = mi4_pkg::MUL_A_W'(
					$signed(cof_rd[mi4_pkg::COF_W-1:mi4_pkg::LO_W]));
			end
		end
	end
	assign mul_b = mi4_pkg::MUL_B_W'(st_rd);
	assign mul_p = mul_a * mul_b;

	always_comb begin
		addend = mi4_pkg::ACC_W'(mul_p);
		if (state_q == mi4_pkg::ST_DET && ph_q == 2'd1) begin
			addend = addend <<< mi4_pkg::LO_W;
		end
		if (state_q == mi4_pkg::ST_COF && term.neg) begin
			acc_sum = acc_q - addend;
		end else begin
			acc_sum = acc_q + addend;
		end
	end

	// One restoring division step.
	assign rem_sh = {rem_q[mi4_pkg::REM_W-2:0], num_q[mi4_pkg::NUM_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dmag_q};

	assign cof_mag = cof_rd[mi4_pkg::COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;

	assign lim = rneg_q ? mi4_pkg::LIM_W'(1 << (mi4_pkg::ELEM_W - 1))
		: mi4_pkg::LIM_W'((1 << (mi4_pkg::ELEM_W - 1)) - 1);
	assign sat = quo_q > mi4_pkg::NUM_W'(lim);
	assign mag = sat ? lim : quo_q[mi4_pkg::LIM_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mi4_pkg::ST_LOAD: if (in_acc && load_cnt_q == 4'd15) state_d = mi4_pkg::ST_COF;
			mi4_pkg::ST_COF: begin
				if (ph_q == 2'd2 && t_q == 3'd5 && k_q == 4'd15) state_d = mi4_pkg::ST_DET;
			end
			mi4_pkg::ST_DET: if (ph_q == 2'd1 && k_q == 4'd3) state_d = mi4_pkg::ST_DFIN;
			mi4_pkg::ST_DFIN: state_d = mi4_pkg::ST_PREP;
			mi4_pkg::ST_PREP: state_d = dzero_q ? mi4_pkg::ST_EMIT : mi4_pkg::ST_DIV;
			mi4_pkg::ST_DIV: if (bit_q == '0) state_d = mi4_pkg::ST_FIN;
			mi4_pkg::ST_FIN: state_d = mi4_pkg::ST_EMIT;
			mi4_pkg::ST_EMIT: begin
				if (out_acc) state_d = (k_q == 4'd15) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_PREP;
			end
			default: state_d = mi4_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		elem.ready       = state_q == mi4_pkg::ST_LOAD;
		res.valid        = state_q == mi4_pkg::ST_EMIT;
		res.result_value = res_val_q;
		res.singular     = res_sing_q;
		res.saturated    = res_sat_q;
		res.last_element = k_q == 4'd15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mi4_pkg::ST_LOAD;
			load_cnt_q <= '0;
			k_q        <= '0;
			t_q        <= '0;
			ph_q       <= '0;
			bit_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mi4_pkg::ST_LOAD: if (in_acc) load_cnt_q <= load_cnt_q + 4'd1;
				mi4_pkg::ST_COF: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (t_q == 3'd5) begin
							t_q <= '0;
							k_q <= k_q + 4'd1;
						end else begin
							t_q <= t_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				mi4_pkg::ST_DET: begin
					if (ph_q == 2'd1) begin
						ph_q <= '0;
						k_q  <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
					end else begin
						ph_q <= 2'd1;
					end
				end
				mi4_pkg::ST_PREP: bit_q <= mi4_pkg::BIT_W'(mi4_pkg::NUM_W - 1);
				mi4_pkg::ST_DIV: bit_q <= bit_q - 1'b1;
				mi4_pkg::ST_EMIT: if (out_acc) k_q <= k_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			store_q[load_cnt_q] <= elem.element_value;
		end
		unique case (state_q)
			mi4_pkg::ST_LOAD: acc_q <= '0;
			mi4_pkg::ST_COF: begin
				unique case (ph_q)
					2'd0: ea_q <= st_rd;
					2'd1: prod_q <= 32'(mul_p);
					default: begin
						if (t_q == 3'd5) begin
							cof_q[k_q] <= acc_sum[mi4_pkg::COF_W-1:0];
							acc_q      <= '0;
						end else begin
							acc_q <= acc_sum;
						end
					end
				endcase
			end
			mi4_pkg::ST_DET: acc_q <= acc_sum;
			mi4_pkg::ST_DFIN: begin
				dneg_q  <= acc_q[mi4_pkg::ACC_W-1];
				dzero_q <= acc_q == '0;
				dmag_q  <= acc_q[mi4_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
			end
			mi4_pkg::ST_PREP: begin
				if (dzero_q) begin
					res_val_q  <= st_rd;
					res_sing_q <= 1'b1;
					res_sat_q  <= 1'b0;
				end else begin
					num_q  <= {cof_mag, (2 * mi4_pkg::FRAC_BITS)'(0)};
					rem_q  <= '0;
					quo_q  <= '0;
					rneg_q <= cof_rd[mi4_pkg::COF_W-1] ^ dneg_q;
				end
			end
			mi4_pkg::ST_DIV: begin
				num_q <= num_q << 1;
				quo_q <= {quo_q[mi4_pkg::NUM_W-2:0], rem_ge};
				rem_q <= rem_ge ? rem_sh - {1'b0, dmag_q} : rem_sh;
			end
			mi4_pkg::ST_FIN: begin
				res_val_q  <= rneg_q ? mi4_pkg::ELEM_W'(-mag) : mag[mi4_pkg::ELEM_W-1:0];
				res_sing_q <= 1'b0;
				res_sat_q  <= sat;
			end
			default: ;
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		elem.ready |-> !res.valid)
		else $error("input ready while a result is offered");

	a_sing_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.singular |-> !res.saturated)
		else $error("singular result flagged saturated");

	a_last_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last_element |=> elem.ready)
		else $error("block not ready for the next matrix after the last result");

	a_load_then_cof: assert property (@(posedge clk) disable iff (!arst_n)
		elem.valid && elem.ready && load_cnt_q == 4'd15 |=> !elem.ready && !res.valid)
		else $error("sequencer did not start after the sixteenth element");

endmodule
